[design/aps_pkg.sv]
// Shared constants, codes and helper functions for the AS path tier-1 scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
package aps_pkg;

    localparam int MAX_HITS = 8;
    localparam int LIST_SIZE = 8;
    localparam int HIT_W = $clog2(MAX_HITS);
    localparam int CNT_W = $clog2(MAX_HITS + 1);

    // Segment kinds.
    localparam logic [2:0] SEG_SEQ = 3'd0;
    localparam logic [2:0] SEG_SET = 3'd1;
    localparam logic [2:0] SEG_CSEQ = 3'd2;
    localparam logic [2:0] SEG_CSET = 3'd3;

    // Record kinds.
    localparam logic [1:0] REC_SUMMARY = 2'd0;
    localparam logic [1:0] REC_ORDERED = 2'd1;
    localparam logic [1:0] REC_UNORDERED = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PAIR0 = 3'd0;
    localparam logic [2:0] CFG_PAIR1 = 3'd1;
    localparam logic [2:0] CFG_PAIR2 = 3'd2;
    localparam logic [2:0] CFG_PAIR3 = 3'd3;
    localparam logic [2:0] CFG_COUNT = 3'd4;
    localparam logic [2:0] CFG_ZUNMAP = 3'd5;

    // Path flag bit positions.
    localparam int F_EMPTY = 0;
    localparam int F_TRUNC = 1;
    localparam int F_UNMAPPED = 2;
    localparam int F_ZERO = 3;
    localparam int F_PRIVATE = 4;
    localparam int F_SET = 5;
    localparam int F_CONFED = 6;
    localparam int F_UNKNOWN = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic update;
        logic load_out;
        logic [1:0] out_kind;
        logic [HIT_W-1:0] out_idx;
        logic out_last;
    } aps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic list_empty;
        logic [CNT_W-1:0] ord_cnt;
        logic [CNT_W-1:0] unord_cnt;
    } aps_stat_t;

    // Saturating 16-bit increment.
    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

[design/aps_ctrl.sv]
// Controller state machine of the AS path scanner: input handshake, path
// update and the sequence of summary and hit records. Depends on aps_pkg.
module aps_ctrl
    import aps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic in_action,
    input  logic in_last,
    output logic out_valid,
    input  logic out_stall,
    input  aps_stat_t stat,
    output aps_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic action_reg, action_next;
    logic last_reg, last_next;
    logic out_valid_reg, out_valid_next;
    logic [4:0] idx_reg, idx_next;
    logic [4:0] total;
    logic [4:0] ord5, unord5;
    logic [4:0] hidx;
    logic out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign ord5 = 5'(stat.ord_cnt);
    assign unord5 = 5'(stat.unord_cnt);
    assign total = stat.list_empty ? 5'd1 : 5'd1 + ord5 + unord5;
    assign hidx = idx_reg - 5'd1;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        action_next = action_reg;
        last_next = last_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = in_action;
                    last_next = in_last;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                idx_next = 5'd0;
                state_next = (action_reg || last_reg) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    out_valid_next = 1'b1;
                    if (idx_reg == 5'd0 || action_reg)
                    begin
                        cmd.out_kind = REC_SUMMARY;
                    end
                    else if (hidx < ord5)
                    begin
                        cmd.out_kind = REC_ORDERED;
                        cmd.out_idx = HIT_W'(hidx);
                    end
                    else
                    begin
                        cmd.out_kind = REC_UNORDERED;
                        cmd.out_idx = HIT_W'(hidx - ord5);
                    end
                    cmd.out_last = action_reg || (idx_reg + 5'd1 == total);
                    idx_next = idx_reg + 5'd1;
                    if (cmd.out_last)
                    begin
                        cmd.clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            action_reg <= 1'b0;
            last_reg <= 1'b0;
            idx_reg <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            action_reg <= action_next;
            last_reg <= last_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/aps_dp.sv]
// Datapath of the AS path scanner: configuration, path state, list and hit
// compares, and the output record register. Depends on aps_pkg.
module aps_dp
    import aps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic in_accept,
    input  logic in_action,
    input  logic [31:0] in_asn,
    input  logic [2:0] in_kind,
    input  logic in_first,
    input  aps_cmd_t cmd,
    output aps_stat_t stat,
    output logic [1:0] record_kind,
    output logic [31:0] hit_asn,
    output logic [10:0] flags,
    output logic [15:0] path_hop_count,
    output logic [3:0] ordered_tier1_count,
    output logic [3:0] unordered_tier1_count,
    output logic [15:0] ignored_zero_count,
    output logic [15:0] ignored_unmapped_count,
    output logic [15:0] ignored_private_count,
    output logic [15:0] ignored_confed_count,
    output logic status,
    output logic last_of_run
);

    logic [31:0] list_reg [LIST_SIZE];
    logic [3:0] lcount_reg;
    logic zunmap_reg;
    logic [3:0] used;

    // Latched input transaction.
    logic [31:0] asn_reg;
    logic [2:0] kind_reg;
    logic clr_reg;

    // The empty-path action has no path contents; it is remembered separately.
    logic empty_path;

    // Path state.
    logic prev_valid_reg, prev_valid_next;
    logic [31:0] prev_asn_reg, prev_asn_next;
    logic [31:0] ord_hits_reg [MAX_HITS];
    logic [31:0] unord_hits_reg [MAX_HITS];
    logic [CNT_W-1:0] ord_cnt_reg, ord_cnt_next;
    logic [CNT_W-1:0] unord_cnt_reg, unord_cnt_next;
    logic [7:0] pflags_reg, pflags_next;
    logic [15:0] hops_reg, hops_next;
    logic [15:0] zc_reg, zc_next, uc_reg, uc_next, pc_reg, pc_next, cc_reg, cc_next;
    logic ord_wr, unord_wr;

    // Base state after an optional clear at the start of a path.
    logic b_pv;
    logic [31:0] b_pa;
    logic [CNT_W-1:0] b_oc, b_uc;
    logic [7:0] b_fl;
    logic [15:0] b_hop, b_zc, b_unc, b_pc, b_cc;

    logic in_lst, is_zero, is_priv, ord_dup, unord_dup;

    assign used = (lcount_reg > 4'(LIST_SIZE)) ? 4'(LIST_SIZE) : lcount_reg;
    assign stat.list_empty = (used == 4'd0);
    assign stat.ord_cnt = ord_cnt_reg;
    assign stat.unord_cnt = unord_cnt_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIST_SIZE; i++)
            begin
                list_reg[i] <= '0;
            end
            lcount_reg <= '0;
            zunmap_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAIR0, CFG_PAIR1, CFG_PAIR2, CFG_PAIR3:
                begin
                    for (int i = 0; i < LIST_SIZE; i++)
                    begin
                        if (i / 2 == int'(cfg_index[1:0]))
                        begin
                            list_reg[i] <= (i % 2 == 1) ? cfg_data[63:32] : cfg_data[31:0];
                        end
                    end
                end
                CFG_COUNT: lcount_reg <= cfg_data[3:0];
                CFG_ZUNMAP: zunmap_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the transaction.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            asn_reg <= in_asn;
            kind_reg <= in_kind;
            clr_reg <= in_first || in_action;
            empty_path <= in_action;
        end
    end

    // Compares against the list, the stored hits and the private ranges.
    always_comb
    begin
        in_lst = 1'b0;
        for (int i = 0; i < LIST_SIZE; i++)
        begin
            if (4'(i) < used && list_reg[i] == asn_reg)
                in_lst = 1'b1;
        end
        ord_dup = 1'b0;
        unord_dup = 1'b0;
        for (int i = 0; i < MAX_HITS; i++)
        begin
            if (CNT_W'(i) < b_oc && ord_hits_reg[i] == asn_reg)
                ord_dup = 1'b1;
            if (CNT_W'(i) < b_uc && unord_hits_reg[i] == asn_reg)
                unord_dup = 1'b1;
        end
        is_zero = (asn_reg == 32'd0);
        is_priv = (asn_reg >= 32'd64512 && asn_reg <= 32'd65534) ||
                  (asn_reg >= 32'd4200000000 && asn_reg <= 32'd4294967294);
    end

    // Path update.
    always_comb
    begin
        b_pv = clr_reg ? 1'b0 : prev_valid_reg;
        b_pa = clr_reg ? '0 : prev_asn_reg;
        b_oc = clr_reg ? '0 : ord_cnt_reg;
        b_uc = clr_reg ? '0 : unord_cnt_reg;
        b_fl = clr_reg ? '0 : pflags_reg;
        b_hop = clr_reg ? '0 : hops_reg;
        b_zc = clr_reg ? '0 : zc_reg;
        b_unc = clr_reg ? '0 : uc_reg;
        b_pc = clr_reg ? '0 : pc_reg;
        b_cc = clr_reg ? '0 : cc_reg;
        prev_valid_next = b_pv;
        prev_asn_next = b_pa;
        ord_cnt_next = b_oc;
        unord_cnt_next = b_uc;
        pflags_next = b_fl;
        hops_next = b_hop;
        zc_next = b_zc;
        uc_next = b_unc;
        pc_next = b_pc;
        cc_next = b_cc;
        ord_wr = 1'b0;
        unord_wr = 1'b0;
        case (kind_reg)
            SEG_SEQ, SEG_SET:
            begin
                if (kind_reg == SEG_SET)
                    pflags_next[F_SET] = 1'b1;
                if (is_zero)
                begin
                    if (kind_reg == SEG_SEQ && zunmap_reg)
                    begin
                        pflags_next[F_UNMAPPED] = 1'b1;
                        uc_next = sat_inc(b_unc);
                    end
                    else
                    begin
                        pflags_next[F_ZERO] = 1'b1;
                        zc_next = sat_inc(b_zc);
                    end
                end
                else if (is_priv)
                begin
                    pflags_next[F_PRIVATE] = 1'b1;
                    pc_next = sat_inc(b_pc);
                end
                else if (kind_reg == SEG_SEQ)
                begin
                    if (!(b_pv && b_pa == asn_reg))
                    begin
                        prev_valid_next = 1'b1;
                        prev_asn_next = asn_reg;
                        hops_next = sat_inc(b_hop);
                        if (in_lst && !ord_dup)
                        begin
                            if (b_oc >= CNT_W'(MAX_HITS))
                                pflags_next[F_TRUNC] = 1'b1;
                            else
                            begin
                                ord_wr = 1'b1;
                                ord_cnt_next = b_oc + 1'b1;
                            end
                        end
                    end
                end
                else if (in_lst && !unord_dup)
                begin
                    if (b_uc >= CNT_W'(MAX_HITS))
                        pflags_next[F_TRUNC] = 1'b1;
                    else
                    begin
                        unord_wr = 1'b1;
                        unord_cnt_next = b_uc + 1'b1;
                    end
                end
            end
            SEG_CSEQ, SEG_CSET:
            begin
                pflags_next[F_CONFED] = 1'b1;
                cc_next = sat_inc(b_cc);
            end
            default:
            begin
                pflags_next[F_UNKNOWN] = 1'b1;
            end
        endcase
    end

    // Path state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_asn_reg <= '0;
            ord_cnt_reg <= '0;
            unord_cnt_reg <= '0;
            pflags_reg <= '0;
            hops_reg <= '0;
            zc_reg <= '0;
            uc_reg <= '0;
            pc_reg <= '0;
            cc_reg <= '0;
        end
        else if (cmd.clear)
        begin
            prev_valid_reg <= 1'b0;
            prev_asn_reg <= '0;
            ord_cnt_reg <= '0;
            unord_cnt_reg <= '0;
            pflags_reg <= '0;
            hops_reg <= '0;
            zc_reg <= '0;
            uc_reg <= '0;
            pc_reg <= '0;
            cc_reg <= '0;
        end
        else if (cmd.update)
        begin
            prev_valid_reg <= prev_valid_next;
            prev_asn_reg <= prev_asn_next;
            ord_cnt_reg <= ord_cnt_next;
            unord_cnt_reg <= unord_cnt_next;
            pflags_reg <= pflags_next;
            hops_reg <= hops_next;
            zc_reg <= zc_next;
            uc_reg <= uc_next;
            pc_reg <= pc_next;
            cc_reg <= cc_next;
        end
    end

    // Hit stores, written at the current count.
    always_ff @(posedge clk)
    begin
        if (cmd.update && ord_wr)
            ord_hits_reg[HIT_W'(b_oc)] <= asn_reg;
        if (cmd.update && unord_wr)
            unord_hits_reg[HIT_W'(b_uc)] <= asn_reg;
    end

    // Output record register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            record_kind <= cmd.out_kind;
            last_of_run <= cmd.out_last;
            hit_asn <= '0;
            flags <= '0;
            path_hop_count <= '0;
            ordered_tier1_count <= '0;
            unordered_tier1_count <= '0;
            ignored_zero_count <= '0;
            ignored_unmapped_count <= '0;
            ignored_private_count <= '0;
            ignored_confed_count <= '0;
            status <= 1'b0;
            case (cmd.out_kind)
                REC_ORDERED: hit_asn <= ord_hits_reg[cmd.out_idx];
                REC_UNORDERED: hit_asn <= unord_hits_reg[cmd.out_idx];
                default:
                begin
                    if (stat.list_empty)
                        status <= 1'b1;
                    else if (empty_path)
                        flags <= 11'd1 << F_EMPTY;
                    else
                    begin
                        flags <= {ord_cnt_reg != '0 || unord_cnt_reg != '0,
                                  unord_cnt_reg != '0, ord_cnt_reg != '0, pflags_reg};
                        path_hop_count <= hops_reg;
                        ordered_tier1_count <= 4'(ord_cnt_reg);
                        unordered_tier1_count <= 4'(unord_cnt_reg);
                        ignored_zero_count <= zc_reg;
                        ignored_unmapped_count <= uc_reg;
                        ignored_private_count <= pc_reg;
                        ignored_confed_count <= cc_reg;
                    end
                end
            endcase
        end
    end

endmodule

[design/as_path_tier_list_scan.sv]
// AS path tier-1 scanner top level. Each element passes through capture and path
// update, and a new element is accepted only after the update of the last one. After a
// path end or an action the summary record is registered after the path update, followed by
// the ordered and unordered hits at one record per cycle, paced by the output stall.
// Reset clears configuration and all path state at once; no clearing pass.
// Depends on aps_pkg, aps_ctrl and aps_dp.
module as_path_tier_list_scan
    import aps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic action,
    input  logic [31:0] asn,
    input  logic [2:0] segment_kind,
    input  logic first_in_path,
    input  logic last_in_path,
    output logic out_valid,
    input  logic out_stall,
    output logic [1:0] record_kind,
    output logic [31:0] hit_asn,
    output logic [10:0] flags,
    output logic [15:0] path_hop_count,
    output logic [3:0] ordered_tier1_count,
    output logic [3:0] unordered_tier1_count,
    output logic [15:0] ignored_zero_count,
    output logic [15:0] ignored_unmapped_count,
    output logic [15:0] ignored_private_count,
    output logic [15:0] ignored_confed_count,
    output logic status,
    output logic last_of_run
);

    aps_cmd_t cmd;
    aps_stat_t stat;
    logic in_accept;

    assign in_accept = in_valid && !in_stall;

    aps_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_action(action),
        .in_last(last_in_path),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .stat(stat),
        .cmd(cmd)
    );

    aps_dp u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_accept(in_accept),
        .in_action(action),
        .in_asn(asn),
        .in_kind(segment_kind),
        .in_first(first_in_path),
        .cmd(cmd),
        .stat(stat),
        .record_kind(record_kind),
        .hit_asn(hit_asn),
        .flags(flags),
        .path_hop_count(path_hop_count),
        .ordered_tier1_count(ordered_tier1_count),
        .unordered_tier1_count(unordered_tier1_count),
        .ignored_zero_count(ignored_zero_count),
        .ignored_unmapped_count(ignored_unmapped_count),
        .ignored_private_count(ignored_private_count),
        .ignored_confed_count(ignored_confed_count),
        .status(status),
        .last_of_run(last_of_run)
    );

endmodule
